// File: hw/rtl/potts_pkg.sv
package potts_pkg;

  // Field widths
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned SPIN_W   = 10;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned Q_W      = 4;
  localparam int unsigned ST_W     = 3;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned ROM_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Table sizes
  localparam int unsigned MAX_SPINS  = 1024;
  localparam int unsigned MAX_EDGES  = 4096;
  localparam int unsigned MAX_STATES = 8;
  localparam int unsigned EDGE_W     = 2 * SPIN_W;

  localparam logic [CNT_W-1:0]  NO_BEST      = '1;
  localparam logic [CNT_W-1:0]  EDGE_LIMIT   = CNT_W'(MAX_EDGES);
  localparam logic [STEP_W-1:0] STEP_MAX     = '1;
  localparam logic [Q_W-1:0]    Q_MIN        = Q_W'(2);
  localparam logic [Q_W-1:0]    Q_MAX        = Q_W'(MAX_STATES);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOTAL  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_SPIN  = 2'd1,
    MODE_EVAL  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_SPIN = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [SPIN_W-1:0] src;
    logic [SPIN_W-1:0] dst;
  } edge_wr_t;

  typedef struct packed {
    logic              we;
    logic [SPIN_W-1:0] addr;
    logic [ST_W-1:0]   state;
  } spin_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0]  energy;
    logic [CNT_W-1:0]  cut;
    logic              improved;
    logic [CNT_W-1:0]  low_energy;
    logic [STEP_W-1:0] low_step;
  } eval_res_t;

  // cos and sin of 2*pi*k/q in Q1.14, indexed [q][k]
  localparam logic signed [ROM_W-1:0] COS_ROM [0:8][0:7] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063, 16'sd0, 16'sd0,
      16'sd0},
    '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192, 16'sd8192, 16'sd0,
      16'sd0},
    '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761, -16'sd3646,
      16'sd10215, 16'sd0},
    '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585, 16'sd0,
      16'sd11585}
  };

  localparam logic signed [ROM_W-1:0] SIN_ROM [0:8][0:7] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd14189, -16'sd14189, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd15582, 16'sd9630, -16'sd9630, -16'sd15582, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd14189, 16'sd14189, 16'sd0, -16'sd14189, -16'sd14189, 16'sd0,
      16'sd0},
    '{16'sd0, 16'sd12810, 16'sd15973, 16'sd7109, -16'sd7109, -16'sd15973,
      -16'sd12810, 16'sd0},
    '{16'sd0, 16'sd11585, 16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384,
      -16'sd11585}
  };

endpackage

// File: hw/rtl/potts_item_if.sv
interface potts_item_if;
  import potts_pkg::*;

  logic                       valid;
  logic                       ready;
  mode_t                      mode;
  logic [SLOT_W-1:0]          edge_slot;
  logic [SPIN_W-1:0]          edge_source;
  logic [SPIN_W-1:0]          edge_target;
  logic [SPIN_W-1:0]          spin_index;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;

  modport source (
    output valid, mode, edge_slot, edge_source, edge_target, spin_index,
           sample_re, sample_im,
    input  ready
  );

  modport sink (
    input  valid, mode, edge_slot, edge_source, edge_target, spin_index,
           sample_re, sample_im,
    output ready
  );
endinterface

// File: hw/rtl/potts_result_if.sv
interface potts_result_if;
  import potts_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             result_kind;
  logic [ST_W-1:0]   discrete_state;
  logic [CNT_W-1:0]  energy_count;
  logic [CNT_W-1:0]  cut_count;
  logic              improved;
  logic [CNT_W-1:0]  best_energy_out;
  logic [STEP_W-1:0] best_step_out;

  modport source (
    output valid, result_kind, discrete_state, energy_count, cut_count, improved,
           best_energy_out, best_step_out,
    input  ready
  );

  modport sink (
    input  valid, result_kind, discrete_state, energy_count, cut_count, improved,
           best_energy_out, best_step_out,
    output ready
  );
endinterface

// File: hw/rtl/potts_cfg_if.sv
interface potts_cfg_if;
  import potts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/potts_round.sv
module potts_round (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [potts_pkg::Q_W-1:0]            q,
  input  logic signed [potts_pkg::SAMPLE_W-1:0] re,
  input  logic signed [potts_pkg::SAMPLE_W-1:0] im,
  output logic                                 done,
  output logic [potts_pkg::ST_W-1:0]           state
);
  import potts_pkg::*;

  logic signed [SAMPLE_W-1:0] re_r;
  logic signed [SAMPLE_W-1:0] im_r;
  logic [Q_W-1:0]             q_r;
  logic                       issue;
  logic [ST_W-1:0]            j_cnt;
  logic [ST_W-1:0]            k_cnt;
  logic                       issue_last;
  logic [ST_W-1:0]            k_next;

  logic                       s0_valid;
  logic                       s0_last;
  logic [ST_W-1:0]            s0_j;
  logic signed [ROM_W-1:0]    s0_cos;
  logic signed [ROM_W-1:0]    s0_sin;

  logic                       s1_valid;
  logic                       s1_last;
  logic [ST_W-1:0]            s1_j;
  logic signed [31:0]         p_re;
  logic signed [31:0]         p_im;

  logic signed [32:0]         score;
  logic signed [32:0]         best_score;

  // Walk j over the q phases; k = (j + q/2) mod q follows as a wrapping counter
  assign issue_last = ({1'b0, j_cnt} == (q_r - Q_W'(1)));
  assign k_next     = (({1'b0, k_cnt} + Q_W'(1)) == q_r) ? '0 : k_cnt + ST_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= 1'b0;
    end else if (start) begin
      issue <= 1'b1;
    end else if (issue && issue_last) begin
      issue <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      re_r  <= re;
      im_r  <= im;
      q_r   <= q;
      j_cnt <= '0;
      k_cnt <= q[Q_W-1:1];
    end else if (issue) begin
      j_cnt <= j_cnt + ST_W'(1);
      k_cnt <= k_next;
    end
  end

  // Stage 0: fetch the reference phase
  // Stage 1: multiply by the sample
  // Stage 2: sum and keep the first maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s0_valid <= issue;
      s1_valid <= s0_valid;
      done     <= s1_valid && s1_last;
    end
  end

  assign score = 33'(p_re) + 33'(p_im);

  always_ff @(posedge clk) begin
    s0_last <= issue_last;
    s0_j    <= j_cnt;
    s0_cos  <= COS_ROM[q_r][k_cnt];
    s0_sin  <= SIN_ROM[q_r][k_cnt];

    s1_last <= s0_last;
    s1_j    <= s0_j;
    p_re    <= re_r * s0_cos;
    p_im    <= im_r * s0_sin;

    if (s1_valid && ((s1_j == '0) || (score > best_score))) begin
      best_score <= score;
      state      <= s1_j;
    end
  end

endmodule

// File: hw/rtl/potts_eval.sv
module potts_eval (
  input  logic                          clk,
  input  logic                          rst,
  input  potts_pkg::edge_wr_t           edge_wr,
  input  potts_pkg::spin_wr_t           spin_wr,
  input  logic                          start,
  input  logic                          clear,
  input  logic [potts_pkg::CNT_W-1:0]   n,
  output logic                          done,
  output potts_pkg::eval_res_t          res
);
  import potts_pkg::*;

  logic [EDGE_W-1:0] edge_mem [0:MAX_EDGES-1];
  logic [ST_W-1:0]   spin_mem [0:MAX_SPINS-1];

  logic [EDGE_W-1:0] edge_rd;
  logic [ST_W-1:0]   src_st;
  logic [ST_W-1:0]   dst_st;

  logic              walking;
  logic [CNT_W-1:0]  addr;
  logic [CNT_W-1:0]  addr_inc;
  logic [CNT_W-1:0]  n_r;
  logic              v1;
  logic              last1;
  logic              v2;
  logic              last2;
  logic              fin;
  logic [CNT_W-1:0]  energy;
  logic [CNT_W-1:0]  low_energy;
  logic [STEP_W-1:0] low_step;
  logic [STEP_W-1:0] step_ctr;
  logic              better;

  assign addr_inc = addr + CNT_W'(1);
  assign better   = energy < low_energy;

  // Edge table and spin store, registered reads
  always_ff @(posedge clk) begin
    if (edge_wr.we) begin
      edge_mem[edge_wr.slot] <= {edge_wr.src, edge_wr.dst};
    end
    edge_rd <= edge_mem[addr[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (spin_wr.we) begin
      spin_mem[spin_wr.addr] <= spin_wr.state;
    end
    src_st <= spin_mem[edge_rd[EDGE_W-1:SPIN_W]];
    dst_st <= spin_mem[edge_rd[SPIN_W-1:0]];
  end

  // Walk control: address, edge read, spin read, count
  always_ff @(posedge clk) begin
    if (rst) begin
      walking    <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      fin        <= 1'b0;
      done       <= 1'b0;
      low_energy <= NO_BEST;
      low_step   <= '0;
      step_ctr   <= '0;
    end else begin
      done <= fin;
      fin  <= (start && (n == '0)) || (v2 && last2);
      v1   <= walking;
      v2   <= v1;

      if (start && (n != '0)) begin
        walking <= 1'b1;
      end else if (walking && (addr_inc == n_r)) begin
        walking <= 1'b0;
      end

      // Settle the step: best tracking and step counter
      if (clear) begin
        low_energy <= NO_BEST;
        low_step   <= '0;
      end else if (fin && better) begin
        low_energy <= energy;
        low_step   <= step_ctr;
      end

      if (fin && (step_ctr != STEP_MAX)) begin
        step_ctr <= step_ctr + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    last1 <= addr_inc == n_r;
    last2 <= last1;

    if (start) begin
      n_r    <= n;
      addr   <= '0;
      energy <= '0;
    end else begin
      if (walking) begin
        addr <= addr_inc;
      end
      if (v2 && (src_st == dst_st)) begin
        energy <= energy + CNT_W'(1);
      end
    end

    if (fin) begin
      res.energy     <= energy;
      res.cut        <= n_r - energy;
      res.improved   <= better;
      res.low_energy <= better ? energy : low_energy;
      res.low_step   <= better ? step_ctr : low_step;
    end
  end

endmodule

// File: hw/rtl/potts_state_round_and_cut_eval.sv
// Potts machine readout: phase rounding and cut evaluation.
//
// Channels: item (valid/ready) carries one request per transaction, selected
// by mode: load edge, spin sample, evaluate step or clear best. result
// (valid/ready) returns one transaction for a spin sample or an evaluate
// step; load edge and clear best return nothing. cfg (valid/ready, always
// ready) writes state_count at index 0 and edge_total at index 1; the user
// must write it only while the block is idle; the block does not enforce it.
//
// Sequence: load edge and clear best are written as they are accepted. A spin
// sample is scored by one shared multiplier pair, one reference phase per
// cycle, and its result is then loaded into the output register. An evaluate
// step walks edge_total entries (edge_total clamped to 4096; none when it is
// zero), one entry per cycle through the edge memory and the two read ports
// of the spin memory. One request is taken at a time; item is ready again
// once the result is loaded into the output register.
// A finished result waits in the output register while a new request is
// taken; a further result is held, with no request taken, until it moves out.
// Reset clears the best energy to 8191, best step and step counter to zero,
// state_count to 2 and edge_total to 0; the memories are not cleared.
module potts_state_round_and_cut_eval (
  input logic           clk,
  input logic           rst,
  potts_item_if.sink    item,
  potts_result_if.source result,
  potts_cfg_if.sink     cfg
);
  import potts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_WAIT
  } state_t;

  state_t            state;
  kind_t             kind_r;
  logic [SPIN_W-1:0] spin_idx_r;
  logic [Q_W-1:0]    state_count;
  logic [CNT_W-1:0]  edge_total;
  logic [Q_W-1:0]    q_eff;
  logic [CNT_W-1:0]  n_eff;

  logic              accept;
  logic              out_free;
  logic              load;
  logic              round_start;
  logic              round_done;
  logic [ST_W-1:0]   round_state;
  logic              eval_start;
  logic              eval_done;
  eval_res_t         eval_res;
  edge_wr_t          edge_wr;
  spin_wr_t          spin_wr;

  assign item.ready = state == S_IDLE;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;
  assign load       = (((state == S_BUSY) && (round_done || eval_done)) ||
                       (state == S_WAIT)) && out_free;

  // Clamp the configuration to the supported range
  assign q_eff = (state_count < Q_MIN) ? Q_MIN :
                 (state_count > Q_MAX) ? Q_MAX : state_count;
  assign n_eff = (edge_total > EDGE_LIMIT) ? EDGE_LIMIT : edge_total;

  assign round_start = accept && (item.mode == MODE_SPIN);
  assign eval_start  = accept && (item.mode == MODE_EVAL);

  assign edge_wr.we   = accept && (item.mode == MODE_LOAD);
  assign edge_wr.slot = item.edge_slot;
  assign edge_wr.src  = item.edge_source;
  assign edge_wr.dst  = item.edge_target;

  assign spin_wr.we    = round_done;
  assign spin_wr.addr  = spin_idx_r;
  assign spin_wr.state = round_state;

  potts_round u_round (
    .clk   (clk),
    .rst   (rst),
    .start (round_start),
    .q     (q_eff),
    .re    (item.sample_re),
    .im    (item.sample_im),
    .done  (round_done),
    .state (round_state)
  );

  potts_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .edge_wr (edge_wr),
    .spin_wr (spin_wr),
    .start   (eval_start),
    .clear   (accept && (item.mode == MODE_CLEAR)),
    .n       (n_eff),
    .done    (eval_done),
    .res     (eval_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= Q_MIN;
      edge_total  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_STATE_COUNT: state_count <= cfg.data[Q_W-1:0];
        REG_EDGE_TOTAL:  edge_total  <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (round_start) begin
            state      <= S_BUSY;
            kind_r     <= KIND_SPIN;
            spin_idx_r <= item.spin_index;
          end else if (eval_start) begin
            state  <= S_BUSY;
            kind_r <= KIND_EVAL;
          end
        end
        S_BUSY: begin
          if (round_done || eval_done) begin
            state <= out_free ? S_IDLE : S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Load a finished result, or drop the one just taken
      if (load) begin
        result.valid       <= 1'b1;
        result.result_kind <= kind_r;
        if (kind_r == KIND_SPIN) begin
          result.discrete_state  <= round_state;
          result.energy_count    <= '0;
          result.cut_count       <= '0;
          result.improved        <= 1'b0;
          result.best_energy_out <= '0;
          result.best_step_out   <= '0;
        end else begin
          result.discrete_state  <= '0;
          result.energy_count    <= eval_res.energy;
          result.cut_count       <= eval_res.cut;
          result.improved        <= eval_res.improved;
          result.best_energy_out <= eval_res.low_energy;
          result.best_step_out   <= eval_res.low_step;
        end
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule
